// File: hdl/abrms_pkg.sv
// package for the banked register file: function codes, mode codes, status bits
package abrms_pkg;

    typedef enum logic [2:0] {
        FUNC_READ  = 3'd0,
        FUNC_WRITE = 3'd1,
        FUNC_MODE  = 3'd2,
        FUNC_EXC   = 3'd3,
        FUNC_IRQ   = 3'd4
    } func_t;

    localparam logic [4:0] MODE_USR = 5'h10;
    localparam logic [4:0] MODE_FIQ = 5'h11;
    localparam logic [4:0] MODE_IRQ = 5'h12;
    localparam logic [4:0] MODE_SVC = 5'h13;
    localparam logic [4:0] MODE_ABT = 5'h17;
    localparam logic [4:0] MODE_UND = 5'h1B;
    localparam logic [4:0] MODE_SYS = 5'h1F;

    localparam logic [4:0] SEL_PC   = 5'd15;
    localparam logic [4:0] SEL_CPSR = 5'd16;
    localparam logic [4:0] VEC_RESERVED = 5'h14;
    localparam logic [4:0] VEC_IRQ      = 5'h18;

    localparam logic [31:0] STATUS_RESET = 32'h0000_001F;
    localparam logic [31:0] HIGH_BASE    = 32'hFFFF_0000;
    localparam logic [31:0] WORD_MASK    = 32'hFFFF_FFFC;
    localparam int          BIT_T = 5;
    localparam int          BIT_I = 7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HOLD
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic execute;
    } dp_cmd_t;

    // exception target mode and halt flag for a vector offset
    function automatic logic [5:0] vector_target(input logic [4:0] voff);
        logic [5:0] r;
        begin
            unique case (voff)
                5'h00:        r = {1'b0, MODE_SVC};
                5'h04:        r = {1'b0, MODE_UND};
                5'h08:        r = {1'b0, MODE_SVC};
                5'h0C:        r = {1'b0, MODE_ABT};
                5'h10:        r = {1'b0, MODE_ABT};
                VEC_RESERVED: r = {1'b1, MODE_USR};
                VEC_IRQ:      r = {1'b0, MODE_IRQ};
                5'h1C:        r = {1'b0, MODE_FIQ};
                default:      r = {1'b0, MODE_USR};
            endcase
            return r;
        end
    endfunction

endpackage

// File: hdl/arm_banked_register_mode_switch.sv
// top level of the banked register file with mode switch and exception entry
// Takes one transaction per cycle unless out_ready holds a waiting result: each
// operation (register read or write, mode switch, exception or irq entry) updates
// the registers when taken; its result is shown from an output register in the
// cycle after, and a new one enters as the consumer takes it. The user must write
// high_vectors via cfg_we/cfg_wdata only while the block is idle; not enforced.
module arm_banked_register_mode_switch
    import abrms_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  func,
    input  logic [4:0]  reg_select,
    input  logic [31:0] write_data,
    input  logic [4:0]  new_mode,
    input  logic [4:0]  vector_offset,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] read_data,
    output logic [4:0]  previous_mode,
    output logic        halt_request,
    output logic [31:0] status_word,
    output logic [31:0] fetch_address
);

    dp_cmd_t cmd;

    abrms_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    abrms_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .func          (func),
        .reg_select    (reg_select),
        .write_data    (write_data),
        .new_mode      (new_mode),
        .vector_offset (vector_offset),
        .read_data     (read_data),
        .previous_mode (previous_mode),
        .halt_request  (halt_request),
        .status_word   (status_word),
        .fetch_address (fetch_address)
    );

endmodule

// File: hdl/abrms_ctrl.sv
// controller: input/output handshake state machine
module abrms_ctrl
    import abrms_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output dp_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_HOLD;
            ST_HOLD: if (out_ready && !accept) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        unique case (state_reg)
            ST_IDLE: in_ready = 1'b1;
            ST_HOLD:
            begin
                out_valid = 1'b1;
                in_ready  = out_ready;
            end
            default: in_ready = 1'b0;
        endcase
        cmd.execute = accept;
    end

endmodule

// File: hdl/abrms_dp.sv
// datapath: banked registers, mode switch, exception entry, result register
module abrms_dp
    import abrms_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic [2:0]  func,
    input  logic [4:0]  reg_select,
    input  logic [31:0] write_data,
    input  logic [4:0]  new_mode,
    input  logic [4:0]  vector_offset,
    output logic [31:0] read_data,
    output logic [4:0]  previous_mode,
    output logic        halt_request,
    output logic [31:0] status_word,
    output logic [31:0] fetch_address
);

    logic [31:0] gen_reg   [16];
    logic [31:0] gen_next  [16];
    logic [31:0] fiq_reg   [7];
    logic [31:0] fiq_next  [7];
    logic [31:0] usr_reg   [2];
    logic [31:0] usr_next  [2];
    logic [31:0] oth_reg   [8];
    logic [31:0] oth_next  [8];
    logic [31:0] spb_reg   [5];
    logic [31:0] spb_next  [5];
    logic [31:0] spsr_reg, spsr_next;
    logic [31:0] cpsr_reg, cpsr_next;
    logic [31:0] nf_reg, nf_next;
    logic [31:0] pc_reg, pc_next;
    logic        hv_reg;
    logic [31:0] rd_reg, rd_next;
    logic [4:0]  pm_reg;
    logic        halt_reg, halt_next;

    logic [4:0]  old_m, tgt_m;
    logic        do_switch, exc, do_exc_entry;
    logic [5:0]  vt;
    logic [31:0] base;
    logic [1:0]  old_slot, new_slot;
    logic        old_banked, new_banked;
    logic [31:0] irq_pc;

    always_comb
    begin
        old_m = cpsr_reg[4:0];
        vt    = vector_target(vector_offset);
        base  = hv_reg ? HIGH_BASE : 32'd0;
        irq_pc = (base + {27'd0, VEC_IRQ}) & WORD_MASK;
        exc   = (func == FUNC_EXC);
        do_exc_entry = exc || (func == FUNC_IRQ);
        do_switch = (func == FUNC_MODE) || do_exc_entry;
        if (func == FUNC_MODE)
            tgt_m = new_mode;
        else if (exc)
            tgt_m = vt[4:0];
        else
            tgt_m = MODE_IRQ;
        old_banked = 1'b1;
        unique case (old_m)
            MODE_SVC: old_slot = 2'd0;
            MODE_ABT: old_slot = 2'd1;
            MODE_UND: old_slot = 2'd2;
            MODE_IRQ: old_slot = 2'd3;
            default:
            begin
                old_slot   = 2'd0;
                old_banked = 1'b0;
            end
        endcase
        new_banked = 1'b1;
        unique case (tgt_m)
            MODE_SVC: new_slot = 2'd0;
            MODE_ABT: new_slot = 2'd1;
            MODE_UND: new_slot = 2'd2;
            MODE_IRQ: new_slot = 2'd3;
            default:
            begin
                new_slot   = 2'd0;
                new_banked = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        gen_next  = gen_reg;
        fiq_next  = fiq_reg;
        usr_next  = usr_reg;
        oth_next  = oth_reg;
        spb_next  = spb_reg;
        spsr_next = spsr_reg;
        cpsr_next = cpsr_reg;
        nf_next   = nf_reg;
        pc_next   = pc_reg;
        rd_next   = 32'd0;
        halt_next = 1'b0;

        unique case (func)
            FUNC_READ:
            begin
                if (reg_select < SEL_PC)
                    rd_next = gen_reg[reg_select[3:0]];
                else if (reg_select == SEL_PC)
                    rd_next = pc_reg;
                else if (reg_select == SEL_CPSR)
                    rd_next = cpsr_reg;
            end
            FUNC_WRITE:
            begin
                if (reg_select < SEL_PC)
                    gen_next[reg_select[3:0]] = write_data;
                else if (reg_select == SEL_PC)
                    nf_next = write_data;
            end
            default: ;
        endcase

        if (do_switch)
        begin
            // save old mode bank
            if (old_m == MODE_USR || old_m == MODE_SYS)
            begin
                usr_next[0] = gen_reg[13];
                usr_next[1] = gen_reg[14];
            end
            else if (old_m == MODE_FIQ)
            begin
                for (int i = 0; i < 5; i++)
                begin
                    gen_next[8 + i] = fiq_reg[i];
                    fiq_next[i]     = gen_reg[8 + i];
                end
                fiq_next[5] = gen_reg[13];
                fiq_next[6] = gen_reg[14];
                spb_next[4] = spsr_reg;
            end
            else if (old_banked)
            begin
                oth_next[{old_slot, 1'b0}] = gen_reg[13];
                oth_next[{old_slot, 1'b1}] = gen_reg[14];
                spb_next[{1'b0, old_slot}] = spsr_reg;
            end
            // load new mode bank
            if (tgt_m == MODE_USR || tgt_m == MODE_SYS)
            begin
                gen_next[13] = usr_next[0];
                gen_next[14] = usr_next[1];
            end
            else if (tgt_m == MODE_FIQ)
            begin
                for (int i = 0; i < 5; i++)
                begin
                    fiq_next[i]     = gen_next[8 + i];
                    gen_next[8 + i] = (old_m == MODE_FIQ) ? gen_reg[8 + i] : fiq_reg[i];
                end
                gen_next[13] = fiq_next[5];
                gen_next[14] = fiq_next[6];
                spsr_next    = spb_next[4];
            end
            else if (new_banked)
            begin
                gen_next[13] = oth_next[{new_slot, 1'b0}];
                gen_next[14] = oth_next[{new_slot, 1'b1}];
                spsr_next    = spb_next[{1'b0, new_slot}];
            end
            cpsr_next = {cpsr_reg[31:5], tgt_m};
        end

        if (do_exc_entry)
        begin
            spsr_next = cpsr_reg;
            cpsr_next[BIT_T] = 1'b0;
            cpsr_next[BIT_I] = 1'b1;
            if (exc)
            begin
                gen_next[14] = nf_reg;
                gen_next[15] = base + {27'd0, vector_offset};
                nf_next      = base + {27'd0, vector_offset};
                halt_next    = vt[5];
            end
            else
            begin
                gen_next[14] = pc_reg + 32'd4;
                pc_next      = irq_pc;
                nf_next      = irq_pc + 32'd4;
                gen_next[15] = irq_pc + 32'd8;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++) gen_reg[i] <= 32'd0;
            for (int i = 0; i < 7; i++)  fiq_reg[i] <= 32'd0;
            for (int i = 0; i < 2; i++)  usr_reg[i] <= 32'd0;
            for (int i = 0; i < 8; i++)  oth_reg[i] <= 32'd0;
            for (int i = 0; i < 5; i++)  spb_reg[i] <= 32'd0;
            spsr_reg <= STATUS_RESET;
            cpsr_reg <= STATUS_RESET;
            nf_reg   <= 32'd0;
            pc_reg   <= 32'd0;
            hv_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                hv_reg <= cfg_wdata;
            if (cmd.execute)
            begin
                gen_reg  <= gen_next;
                fiq_reg  <= fiq_next;
                usr_reg  <= usr_next;
                oth_reg  <= oth_next;
                spb_reg  <= spb_next;
                spsr_reg <= spsr_next;
                cpsr_reg <= cpsr_next;
                nf_reg   <= nf_next;
                pc_reg   <= pc_next;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            rd_reg   <= rd_next;
            pm_reg   <= old_m;
            halt_reg <= halt_next;
        end
    end

    assign read_data     = rd_reg;
    assign previous_mode = pm_reg;
    assign halt_request  = halt_reg;
    assign status_word   = cpsr_reg;
    assign fetch_address = nf_reg;

endmodule
